/* src/bdnsm_pkg.sv */
`timescale 1ns / 1ps

package bdnsm_pkg;

	localparam int unsigned MAX_NODES    = 65536;
	localparam int unsigned MAX_SWITCHES = 4096;

	localparam int NODE_W  = 16;
	localparam int SW_W    = 12;
	localparam int BASE_W  = 16;
	localparam int SWCNT_W = 13;
	localparam int CNT_W   = 17;
	localparam int CUT_W   = 29;
	localparam int TOT_W   = 30;

	typedef enum logic [1:0] {
		CFG_BASE  = 2'd0,
		CFG_EXTRA = 2'd1,
		CFG_SWCNT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [BASE_W-1:0]  base;
		logic [SW_W-1:0]    extra;
		logic [SWCNT_W-1:0] swcnt;
	} cfg_t;

	// divider state handed from cell to cell
	typedef struct packed {
		logic [CNT_W-1:0]  rem;
		logic [NODE_W-1:0] quo;
		logic [NODE_W-1:0] dvd;
		logic [CNT_W-1:0]  dvs;
	} div_t;

	// result fields that ride along the divider
	typedef struct packed {
		logic              err;
		logic              func;
		logic [SW_W-1:0]   id_add;
		logic [NODE_W-1:0] first;
		logic [CNT_W-1:0]  count;
	} side_t;

endpackage

/* src/bdnsm_front.sv */
`timescale 1ns / 1ps

module bdnsm_front import bdnsm_pkg::*; #(
	parameter int unsigned NODE_LIMIT   = MAX_NODES,
	parameter int unsigned SWITCH_LIMIT = MAX_SWITCHES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [NODE_W-1:0] node,
	input  logic [SW_W-1:0]   sw,
	output logic              out_valid,
	input  logic              out_ready,
	output div_t              out_div,
	output side_t             out_side
);

	logic              valid_s1, valid_s2;
	logic              ready_s1, ready_s2;
	logic              func_s1;
	logic [NODE_W-1:0] node_s1;
	logic [SW_W-1:0]   sw_s1;
	logic [CUT_W-1:0]  cutoff_s1;
	logic [TOT_W-1:0]  total_s1;
	logic [NODE_W-1:0] low_first_s1;
	logic [NODE_W-1:0] up_prod_s1;
	div_t              div_s2;
	side_t             side_s2;
	div_t              div_d;
	side_t             side_d;
	logic [CNT_W-1:0]  base_p1;

	assign base_p1   = {1'b0, cfg.base} + CNT_W'(1);
	assign ready_s2  = !valid_s2 || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;
	assign out_valid = valid_s2;
	assign out_div   = div_s2;
	assign out_side  = side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			func_s1      <= func;
			node_s1      <= node;
			sw_s1        <= sw;
			cutoff_s1    <= CUT_W'(base_p1) * CUT_W'(cfg.extra);
			total_s1     <= TOT_W'(cfg.base) * TOT_W'(cfg.swcnt) + TOT_W'(cfg.extra);
			low_first_s1 <= NODE_W'(CUT_W'(base_p1) * CUT_W'(sw));
			up_prod_s1   <= NODE_W'(CUT_W'(sw - cfg.extra) * CUT_W'(cfg.base));
		end
		if (ready_s2 && valid_s1) begin
			div_s2  <= div_d;
			side_s2 <= side_d;
		end
	end

	always_comb begin
		logic              node_err, sw_err, upper, sw_up, err, live;
		logic [NODE_W-1:0] off;

		node_err = (TOT_W'(node_s1) >= total_s1) || (32'(node_s1) >= NODE_LIMIT);
		upper    = CUT_W'(node_s1) >= cutoff_s1;
		off      = node_s1 - cutoff_s1[NODE_W-1:0];
		sw_err   = ({1'b0, sw_s1} >= cfg.swcnt) || (32'(sw_s1) >= SWITCH_LIMIT);
		sw_up    = sw_s1 >= cfg.extra;
		err      = func_s1 ? sw_err : (node_err || (upper && cfg.base == '0));
		live     = !func_s1 && !err;

		div_d.rem = '0;
		div_d.quo = '0;
		div_d.dvd = live ? (upper ? off : node_s1) : '0;
		div_d.dvs = upper ? {1'b0, cfg.base} : base_p1;

		side_d.err    = err;
		side_d.func   = func_s1;
		side_d.id_add = upper ? cfg.extra : '0;
		if (func_s1 && !err) begin
			side_d.first = sw_up ? (cutoff_s1[NODE_W-1:0] + up_prod_s1) : low_first_s1;
			side_d.count = sw_up ? {1'b0, cfg.base} : base_p1;
		end else begin
			side_d.first = '0;
			side_d.count = '0;
		end
	end

endmodule

/* src/bdnsm_cell.sv */
`timescale 1ns / 1ps

module bdnsm_cell import bdnsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  div_t  in_div,
	input  side_t in_side,
	output logic  out_valid,
	input  logic  out_ready,
	output div_t  out_div,
	output side_t out_side
);

	logic  valid_q;
	div_t  div_q;
	side_t side_q;
	div_t  div_d;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_div   = div_q;
	assign out_side  = side_q;

	// one restoring step: bring down the next dividend bit
	always_comb begin
		logic [CNT_W:0] rr;
		logic           ge;

		rr        = {in_div.rem, in_div.dvd[NODE_W-1]};
		ge        = rr >= {1'b0, in_div.dvs};
		div_d.rem = ge ? CNT_W'(rr - {1'b0, in_div.dvs}) : CNT_W'(rr);
		div_d.quo = {in_div.quo[NODE_W-2:0], ge};
		div_d.dvd = {in_div.dvd[NODE_W-2:0], 1'b0};
		div_d.dvs = in_div.dvs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			div_q  <= div_d;
			side_q <= in_side;
		end
	end

endmodule

/* src/block_distribution_node_switch_map_core.sv */
`timescale 1ns / 1ps

// Node/switch index map for block distribution with remainder. func 0 turns a node
// number into its switch and port, func 1 turns a switch number into its first node
// and node count; numbers past the configured total return range_error with zeroed
// fields. One request is taken per cycle while the pipeline is not stalled; each
// result passes through two setup stages (products of the configuration and the
// lookup number, then range and branch selection), a chain of 16 divider cells
// that each settle one quotient bit of the node offset, and the output register.
// Each stage holds when the one after it is full and stalled, so bubbles close up
// under back-pressure. The user must write configuration only while no request
// is in flight, through cfg_we/cfg_index/cfg_data; the block does not enforce this.
module block_distribution_node_switch_map_core import bdnsm_pkg::*; #(
	parameter int unsigned NODE_LIMIT   = MAX_NODES,
	parameter int unsigned SWITCH_LIMIT = MAX_SWITCHES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // node_number[15:0], switch_id[27:16], zero pad
	input  logic        s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // owner_switch[11:0], port_on_switch[27:12],
	                              // first_node[43:28], node_count[60:44], zero pad
	output logic        m_tuser   // range_error
);

	cfg_t  cfg_q;
	logic  valid_c [0:NODE_W];
	logic  ready_c [0:NODE_W];
	div_t  div_c   [0:NODE_W];
	side_t side_c  [0:NODE_W];
	logic  m_tvalid_q;
	logic  out_ready;
	logic [63:0] m_tdata_d;
	logic [63:0] m_tdata_q;
	logic        m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base  <= BASE_W'(1);
			cfg_q.extra <= '0;
			cfg_q.swcnt <= SWCNT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BASE:  cfg_q.base  <= cfg_data[BASE_W-1:0];
				CFG_EXTRA: cfg_q.extra <= cfg_data[SW_W-1:0];
				CFG_SWCNT: cfg_q.swcnt <= cfg_data[SWCNT_W-1:0];
				default: ;
			endcase
		end
	end

	bdnsm_front #(
		.NODE_LIMIT   (NODE_LIMIT),
		.SWITCH_LIMIT (SWITCH_LIMIT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.func      (s_tuser),
		.node      (s_tdata[15:0]),
		.sw        (s_tdata[27:16]),
		.out_valid (valid_c[0]),
		.out_ready (ready_c[0]),
		.out_div   (div_c[0]),
		.out_side  (side_c[0])
	);

	for (genvar i = 0; i < NODE_W; i++) begin : g_cell
		bdnsm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_div    (div_c[i]),
			.in_side   (side_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_div   (div_c[i+1]),
			.out_side  (side_c[i+1])
		);
	end

	assign out_ready       = !m_tvalid_q || m_tready;
	assign ready_c[NODE_W] = out_ready;

	always_comb begin
		m_tdata_d = '0;
		if (!side_c[NODE_W].err) begin
			if (side_c[NODE_W].func) begin
				m_tdata_d[43:28] = side_c[NODE_W].first;
				m_tdata_d[60:44] = side_c[NODE_W].count;
			end else begin
				m_tdata_d[11:0]  = div_c[NODE_W].quo[SW_W-1:0] + side_c[NODE_W].id_add;
				m_tdata_d[27:12] = div_c[NODE_W].rem[NODE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_ready)
			m_tvalid_q <= valid_c[NODE_W];
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_c[NODE_W]) begin
			m_tdata_q <= m_tdata_d;
			m_tuser_q <= side_c[NODE_W].err;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* src/bdnsm_chk.sv */
`timescale 1ns / 1ps

module bdnsm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 64'd0)
		else $error("range error with nonzero fields");

	a_func_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[60:44] != 17'd0) |-> m_tdata[27:0] == 28'd0)
		else $error("switch lookup carries node lookup fields");

endmodule

bind block_distribution_node_switch_map_core bdnsm_chk u_bdnsm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
